@@ sv/c2p_pkg.sv @@
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants for the complex-to-polar converter
// Sample and result formats, CORDIC word widths, the arctangent table and
// the inverse gain calculation used by the rotation chain and scaler.
// ----------------------------------------------------------------------------
package c2p_pkg;

    // field and datapath widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int GUARD_BITS   = 12;
    localparam int XY_W         = SAMPLE_WIDTH + GUARD_BITS + 3;
    localparam int Z_W          = 27;
    localparam int MAG_W        = 16;
    localparam int PHASE_W      = 16;
    localparam int TABLE_LEN    = 32;

    // magnitude product: high half times gain plus shifted low half times gain
    localparam int XH_W    = XY_W - 1 - 16;
    localparam int PROD_W  = XH_W + 32 + 1;
    localparam int ROUND_SH = 16 + GUARD_BITS;

    // phase after rounding from 16 to 7 fraction bits
    localparam int PH_WIDE_W = Z_W + 1 - 9;

    localparam logic signed [PHASE_W-1:0] HALF_TURN_Q7    = 16'sd23040;
    localparam logic signed [PHASE_W-1:0] QUARTER_TURN_Q7 = 16'sd11520;
    localparam logic signed [Z_W-1:0]     HALF_TURN_Q16   = 27'sd11796480;

    localparam logic [63:0] INV_GAIN_Q32        = 64'd2608131496;
    localparam logic [63:0] INV_GAIN_TWO_THIRDS = 64'd1738754331;

    typedef logic signed [Z_W-1:0] angle_t;

    // atan(2^-i) in degrees with 16 fraction bits
    localparam angle_t ANGLE_TABLE [TABLE_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0,
        27'sd0,       27'sd0,       27'sd0,      27'sd0,
        27'sd0,       27'sd0,       27'sd0,      27'sd0
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] real_part;
        logic signed [SAMPLE_WIDTH-1:0] imag_part;
    } sample_t;

    typedef struct packed {
        logic        [MAG_W-1:0]   magnitude;
        logic signed [PHASE_W-1:0] phase_deg;
    } polar_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // result for samples on an axis, which skip the rotation result
    typedef struct packed {
        logic   bypass;
        polar_t result;
    } side_t;

    // inverse CORDIC gain in Q32 with the finite-stage correction
    function automatic logic [31:0] inv_gain(input int stages);
        logic [63:0] corr;
        corr = INV_GAIN_TWO_THIRDS >> (2 * stages);
        return 32'(INV_GAIN_Q32 + corr);
    endfunction

endpackage

@@ sv/complex_to_polar_unit.sv @@
// A sample passes the conditioning, rotation cell, scaler and output registers.
// Throughput: one sample per cycle; every stage of the rotation chain is
// registered and the whole pipeline advances together when the output
// register is empty or its result is being taken.
// Reset: synchronous active-low aresetn clears all stage valid flags and
// the output valid flag; data registers are not reset.
// ----------------------------------------------------------------------------
// complex_to_polar_unit: pipelined rectangular to polar converter
// Conditioning stage, a chain of CORDIC vectoring cells, a gain-correction
// stage and an output register on a valid/ready stream.
// ----------------------------------------------------------------------------
module complex_to_polar_unit #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  c2p_pkg::sample_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output c2p_pkg::polar_t   m_payload
);

    localparam logic [31:0] INV_GAIN = c2p_pkg::inv_gain(ROTATION_STAGES);

    logic              adv;
    logic              chain_valid [ROTATION_STAGES+1];
    c2p_pkg::cordic_t  chain_data  [ROTATION_STAGES+1];
    c2p_pkg::side_t    chain_side  [ROTATION_STAGES+1];

    logic              scale_valid;
    c2p_pkg::polar_t   scale_result;

    logic              m_valid_reg;
    c2p_pkg::polar_t   m_payload_reg;

    // pipeline moves whenever the output register can take a result
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    c2p_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_sample (s_payload),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_side  (chain_side[0])
    );

    // rotation chain
    for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
        c2p_cell #(
            .STAGE_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    c2p_scale #(
        .INV_GAIN (INV_GAIN)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (chain_valid[ROTATION_STAGES]),
        .in_data    (chain_data[ROTATION_STAGES]),
        .in_side    (chain_side[ROTATION_STAGES]),
        .out_valid  (scale_valid),
        .out_result (scale_result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= scale_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload_reg <= scale_result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef ASSERT_OFF
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && scale_valid |=> m_valid && (m_payload == $past(scale_result)))
        else $error("result from scaler not taken into output register");

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.phase_deg <= c2p_pkg::HALF_TURN_Q7) &&
                    (m_payload.phase_deg >= -c2p_pkg::HALF_TURN_Q7))
        else $error("phase outside half turn");

    a_cell_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && chain_valid[0] |=> chain_valid[1])
        else $error("first rotation cell lost a sample");
`endif

endmodule

@@ sv/c2p_prep.sv @@
// ----------------------------------------------------------------------------
// c2p_prep: input conditioning stage
// Folds left half plane samples into the right half plane, seeds the angle
// accumulator and resolves samples lying on an axis directly.
// ----------------------------------------------------------------------------
module c2p_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  c2p_pkg::sample_t  in_sample,
    output logic              out_valid,
    output c2p_pkg::cordic_t  out_data,
    output c2p_pkg::side_t    out_side
);

    logic                                   valid_reg;
    c2p_pkg::cordic_t                       data_reg, data_next;
    c2p_pkg::side_t                         side_reg, side_next;

    logic signed [c2p_pkg::SAMPLE_WIDTH:0]  re_ext, im_ext, re_abs, im_abs;
    logic signed [c2p_pkg::XY_W-1:0]        re_wide, im_wide;
    logic                                   re_neg, im_neg, re_zero, im_zero;

    // sign handling and axis detection
    always_comb begin
        re_ext  = (c2p_pkg::SAMPLE_WIDTH + 1)'(in_sample.real_part);
        im_ext  = (c2p_pkg::SAMPLE_WIDTH + 1)'(in_sample.imag_part);
        re_neg  = in_sample.real_part[c2p_pkg::SAMPLE_WIDTH-1];
        im_neg  = in_sample.imag_part[c2p_pkg::SAMPLE_WIDTH-1];
        re_zero = (in_sample.real_part == '0);
        im_zero = (in_sample.imag_part == '0);
        re_abs  = re_neg ? -re_ext : re_ext;
        im_abs  = im_neg ? -im_ext : im_ext;
        re_wide = c2p_pkg::XY_W'(re_ext) <<< c2p_pkg::GUARD_BITS;
        im_wide = c2p_pkg::XY_W'(im_ext) <<< c2p_pkg::GUARD_BITS;
    end

    // seed values for the rotation chain
    always_comb begin
        if (re_neg) begin
            data_next.x = -re_wide;
            data_next.y = -im_wide;
            data_next.z = im_neg ? -c2p_pkg::HALF_TURN_Q16 : c2p_pkg::HALF_TURN_Q16;
        end else begin
            data_next.x = re_wide;
            data_next.y = im_wide;
            data_next.z = '0;
        end
    end

    // axis samples bypass the rotations
    always_comb begin
        side_next.bypass = im_zero || re_zero;
        if (im_zero) begin
            side_next.result.magnitude = c2p_pkg::MAG_W'(re_abs);
            side_next.result.phase_deg = re_neg ? c2p_pkg::HALF_TURN_Q7 : '0;
        end else begin
            side_next.result.magnitude = c2p_pkg::MAG_W'(im_abs);
            side_next.result.phase_deg = im_neg ? -c2p_pkg::QUARTER_TURN_Q7
                                                : c2p_pkg::QUARTER_TURN_Q7;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

@@ sv/c2p_cell.sv @@
// ----------------------------------------------------------------------------
// c2p_cell: one CORDIC micro-rotation in vectoring mode
// Turns the vector towards the real axis by atan(2^-STAGE_IDX) and adds or
// subtracts the angle in the accumulator, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module c2p_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  c2p_pkg::cordic_t  in_data,
    input  c2p_pkg::side_t    in_side,
    output logic              out_valid,
    output c2p_pkg::cordic_t  out_data,
    output c2p_pkg::side_t    out_side
);

    logic                             valid_reg;
    c2p_pkg::cordic_t                 data_reg, data_next;
    c2p_pkg::side_t                   side_reg;

    logic signed [c2p_pkg::XY_W-1:0]  x_in, y_in, xs, ys;
    c2p_pkg::angle_t                  z_in;

    // shifted cross terms, floor shift
    always_comb begin
        x_in = in_data.x;
        y_in = in_data.y;
        z_in = in_data.z;
        xs   = x_in >>> STAGE_IDX;
        ys   = y_in >>> STAGE_IDX;
    end

    // rotate against the sign of y
    always_comb begin
        if (!y_in[c2p_pkg::XY_W-1]) begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = z_in + c2p_pkg::ANGLE_TABLE[STAGE_IDX];
        end else begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = z_in - c2p_pkg::ANGLE_TABLE[STAGE_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

@@ sv/c2p_scale.sv @@
// ----------------------------------------------------------------------------
// c2p_scale: gain correction and output formatting
// Multiplies the grown real part by the inverse CORDIC gain in one
// registered stage, then rounds and saturates magnitude and phase.
// ----------------------------------------------------------------------------
module c2p_scale #(
    parameter logic [31:0] INV_GAIN = 32'd2608131496
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  c2p_pkg::cordic_t  in_data,
    input  c2p_pkg::side_t    in_side,
    output logic              out_valid,
    output c2p_pkg::polar_t   out_result
);

    localparam logic [c2p_pkg::PROD_W-1:0] ROUND_HALF =
        c2p_pkg::PROD_W'(1) << (c2p_pkg::ROUND_SH - 1);

    logic                                    valid_reg;
    logic [c2p_pkg::PROD_W-1:0]              hi_reg, hi_next;
    logic [31:0]                             lo_reg, lo_next;
    logic signed [c2p_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    c2p_pkg::side_t                          side_reg;

    logic [c2p_pkg::XY_W-2:0]                ux;
    logic [c2p_pkg::XH_W+31:0]               hi_prod;
    logic [47:0]                             lo_prod;
    logic signed [c2p_pkg::Z_W:0]            z_round;
    logic signed [c2p_pkg::PH_WIDE_W-1:0]    ph_wide;

    logic [c2p_pkg::PROD_W-1:0]              p_sum;
    logic [c2p_pkg::PROD_W-c2p_pkg::ROUND_SH-1:0] mag_wide;
    logic [c2p_pkg::MAG_W-1:0]               mag_sat;

    // gain products, negative x clamps to zero
    always_comb begin
        ux      = in_data.x[c2p_pkg::XY_W-1] ? '0 : in_data.x[c2p_pkg::XY_W-2:0];
        hi_prod = ux[c2p_pkg::XY_W-2:16] * INV_GAIN;
        lo_prod = ux[15:0] * INV_GAIN;
        hi_next = c2p_pkg::PROD_W'(hi_prod);
        lo_next = lo_prod[47:16];
    end

    // phase rounding half up to 7 fraction bits with saturation
    always_comb begin
        z_round = (c2p_pkg::Z_W + 1)'(in_data.z) + (c2p_pkg::Z_W + 1)'(256);
        ph_wide = c2p_pkg::PH_WIDE_W'(z_round >>> 9);
        priority if (ph_wide > c2p_pkg::PH_WIDE_W'(c2p_pkg::HALF_TURN_Q7)) begin
            phase_next = c2p_pkg::HALF_TURN_Q7;
        end else if (ph_wide < -c2p_pkg::PH_WIDE_W'(c2p_pkg::HALF_TURN_Q7)) begin
            phase_next = -c2p_pkg::HALF_TURN_Q7;
        end else begin
            phase_next = c2p_pkg::PHASE_W'(ph_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            phase_reg <= phase_next;
            side_reg  <= in_side;
        end
    end

    // final sum, rounding and saturation of the magnitude
    always_comb begin
        p_sum    = hi_reg + c2p_pkg::PROD_W'(lo_reg) + ROUND_HALF;
        mag_wide = p_sum[c2p_pkg::PROD_W-1:c2p_pkg::ROUND_SH];
        mag_sat  = (mag_wide > (c2p_pkg::PROD_W - c2p_pkg::ROUND_SH)'(16'hFFFF))
                   ? '1 : c2p_pkg::MAG_W'(mag_wide);
    end

    // axis samples take their precomputed result
    always_comb begin
        if (side_reg.bypass) begin
            out_result = side_reg.result;
        end else begin
            out_result.magnitude = mag_sat;
            out_result.phase_deg = phase_reg;
        end
    end

    assign out_valid = valid_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the complex-to-polar converter
// Drives complex samples over the valid/ready input with random gaps,
// throttles the result side, and compares every result with a bit-exact
// CORDIC vectoring prediction of magnitude and phase in degrees.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROT_STAGES     = 16;
    localparam int GUARD          = 12;
    localparam int LATENCY        = ROT_STAGES + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED     = 22;
    localparam int N_RANDOM       = 630;
    localparam int N_CALM         = 100;

    localparam longint HALF_Q7    = 23040;
    localparam longint QUARTER_Q7 = 11520;
    localparam longint HALF_Q16   = 11796480;
    localparam longint GAIN_Q32   = 64'd2608131496;
    localparam longint GAIN_CORR  = 64'd1738754331;

    // arctangent of 2^-i in degrees, 16 fraction bits
    localparam longint ATAN_DEG [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // corner samples: axes, extremes, both half planes
    localparam int DIR_RE [N_DIRECTED] = '{
        0, 32767, -32768, -1, 0, 0, 0, 0, 32767, -32768, -32768,
        32767, 1, -1, -1, 1, -32768, -32768, 32767, 1, -3, 12345
    };
    localparam int DIR_IM [N_DIRECTED] = '{
        0, 0, 0, 0, 32767, -32768, 1, -1, 32767, -32768, 32767,
        -32768, 1, 1, -1, -1, 1, -1, 1, 32767, -32768, -23456
    };

    // expected polar results for accepted samples, oldest first
    class polar_tally;
        c2p_pkg::polar_t polar_due [$];
        int unsigned     errors;
        int unsigned     compared;
        int unsigned     samples;
        int unsigned     on_axis;
        int unsigned     left_half;

        function logic [15:0] clip_mag(bit [63:0] m);
            return (m > 64'd65535) ? 16'hFFFF : m[15:0];
        endfunction

        // vectoring CORDIC with floor shifts, gain scaling and rounding
        function c2p_pkg::polar_t to_polar(c2p_pkg::sample_t smp);
            longint          re, im, x, y, z, xs, ys, ph;
            bit [63:0]       ux, xh, xl, gain, prod, mag;
            c2p_pkg::polar_t r;
            re = longint'($signed(smp.real_part));
            im = longint'($signed(smp.imag_part));
            if (im == 0) begin
                r.magnitude = clip_mag(64'(re < 0 ? -re : re));
                r.phase_deg = (re < 0) ? 16'(HALF_Q7) : 16'sd0;
                return r;
            end
            if (re == 0) begin
                r.magnitude = clip_mag(64'(im < 0 ? -im : im));
                r.phase_deg = (im < 0) ? 16'(-QUARTER_Q7) : 16'(QUARTER_Q7);
                return r;
            end
            z = 0;
            if (re < 0) begin
                x = -re * (longint'(1) << GUARD);
                y = -im * (longint'(1) << GUARD);
                z = (im > 0) ? HALF_Q16 : -HALF_Q16;
            end else begin
                x = re * (longint'(1) << GUARD);
                y = im * (longint'(1) << GUARD);
            end
            for (int i = 0; i < ROT_STAGES && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG[i];
                end
            end
            ux   = (x < 0) ? 64'd0 : 64'(x);
            xh   = ux >> 16;
            xl   = ux & 64'hFFFF;
            gain = 64'(GAIN_Q32);
            if (2 * ROT_STAGES < 40)
                gain = gain + (64'(GAIN_CORR) >> (2 * ROT_STAGES));
            prod = xh * gain + ((xl * gain) >> 16);
            mag  = (prod + (64'd1 << (16 + GUARD - 1))) >> (16 + GUARD);
            r.magnitude = clip_mag(mag);
            ph = (z + 256) >>> 9;
            if (ph > HALF_Q7)
                ph = HALF_Q7;
            if (ph < -HALF_Q7)
                ph = -HALF_Q7;
            r.phase_deg = 16'(ph);
            return r;
        endfunction

        function void note_sample(c2p_pkg::sample_t smp);
            samples++;
            if (smp.real_part == 0 || smp.imag_part == 0)
                on_axis++;
            if (smp.real_part < 0)
                left_half++;
            polar_due.push_back(to_polar(smp));
        endfunction

        function void check_polar(c2p_pkg::polar_t got);
            c2p_pkg::polar_t want;
            if (polar_due.size() == 0) begin
                $error("result with no sample outstanding: magnitude %0d phase %0d",
                       got.magnitude, $signed(got.phase_deg));
                errors++;
                return;
            end
            want = polar_due.pop_front();
            compared++;
            if (got.magnitude !== want.magnitude) begin
                $error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
                errors++;
            end
            if (got.phase_deg !== want.phase_deg) begin
                $error("phase_deg: expected %0d, got %0d",
                       $signed(want.phase_deg), $signed(got.phase_deg));
                errors++;
            end
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    c2p_pkg::sample_t s_payload = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    c2p_pkg::polar_t  m_payload;

    bit          calm = 1'b0;
    int unsigned quiet_cycles = 0;
    polar_tally  tally = new();

    complex_to_polar_unit #(
        .ROTATION_STAGES (ROT_STAGES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tally.note_sample(s_payload);
            if (m_valid && m_ready)
                tally.check_polar(m_payload);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side back-pressure in random bursts
    initial begin : result_sink
        while (!aresetn)
            @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if (calm) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                if (!calm && $urandom_range(0, 2) != 0) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 14)) @(posedge aclk);
                end
            end
        end
    end

    // present one sample and hold it until the transfer
    task automatic push_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        c2p_pkg::sample_t smp;
        smp.real_part = re;
        smp.imag_part = im;
        s_valid   <= 1'b1;
        s_payload <= smp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic hold_off(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tally.polar_due.size() != 0)
            @(posedge aclk);
    endtask

    // random sample, biased towards axes, small values and the extremes
    task automatic push_random(input int gap_odds);
        logic signed [15:0] re, im;
        int                 pick;
        pick = $urandom_range(0, 99);
        re   = 16'($urandom);
        im   = 16'($urandom);
        if (pick < 15) begin
            re = 16'(int'($urandom_range(0, 128)) - 64);
            im = 16'(int'($urandom_range(0, 128)) - 64);
        end else if (pick < 25) begin
            if ($urandom_range(0, 1))
                re = '0;
            else
                im = '0;
        end else if (pick < 35) begin
            if ($urandom_range(0, 1))
                im = 16'(int'($urandom_range(0, 6)) - 3);
            else
                re = 16'(int'($urandom_range(0, 6)) - 3);
        end else if (pick < 45) begin
            re = $urandom_range(0, 1) ? 16'(-32768 + int'($urandom_range(0, 15)))
                                      : 16'(32767 - int'($urandom_range(0, 15)));
            im = $urandom_range(0, 1) ? 16'(-32768 + int'($urandom_range(0, 15)))
                                      : 16'(32767 - int'($urandom_range(0, 15)));
        end else if (pick < 60) begin
            re = 16'(-int'($urandom_range(1, 32768)));
        end
        if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds)
            hold_off($urandom_range(1, 14));
        push_sample(re, im);
    endtask

    initial begin : stimulus
        int gap_odds;
        gap_odds = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        for (int k = 0; k < N_DIRECTED; k++) begin
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 14));
            push_sample(16'(DIR_RE[k]), 16'(DIR_IM[k]));
        end
        wait_drained();

        // random mix; gap rate changes per block so some stretches run flat out
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2)
                wait_drained();
            if (k == N_RANDOM - N_CALM)
                calm = 1'b1;
            if (k % 64 == 0)
                gap_odds = $urandom_range(0, 1) ? 25 : 0;
            push_random(calm ? 0 : gap_odds);
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge aclk);

        $display("run covered %0d samples, %0d on an axis, %0d in the left half plane",
                 tally.samples, tally.on_axis, tally.left_half);
        $display("%0d results compared, %0d mismatches", tally.compared, tally.errors);
        if (tally.errors == 0 && tally.polar_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
